>>> hw/rtl/bcq_pkg.sv
// Shared types and codes for the button click qualifier.
// Stage encoding, click event codes, register indexes and the config bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bcq_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERFERENCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_CLICK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_MODE   = 3'd3;

  localparam logic [15:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [15:0] INTERFERENCE_RST = 16'd50;
  localparam logic [15:0] LONG_CLICK_RST   = 16'd1000;

  typedef enum logic [1:0] {
    EV_NONE         = 2'd0,
    EV_SINGLE       = 2'd1,
    EV_LONG_PRESS   = 2'd2,
    EV_LONG_RELEASE = 2'd3
  } event_t;

  typedef enum logic [6:0] {
    ST_PASSIVE       = 7'b0000001,
    ST_DEB_PRESS     = 7'b0000010,
    ST_INT_PRESS     = 7'b0000100,
    ST_WAIT_REL      = 7'b0001000,
    ST_WAIT_REL_LONG = 7'b0010000,
    ST_DEB_REL       = 7'b0100000,
    ST_INT_REL       = 7'b1000000
  } stage_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] interference_ticks;
    logic [15:0] long_click_ticks;
    logic        click_mode;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/button_click_qualifier_unit.sv
// Top level of the button click qualifier: config registers, input word register,
// result register and the qualifier core.
// Depends on bcq_pkg and bcq_core.
`timescale 1ns / 1ps
`default_nettype none

// One pin sample is taken per word, one word per clock sustained while out_ready holds;
// the click event for a sample passes the input register, then the single-pass qualifier
// logic into the result register. A stalled result holds the core, and the input
// register absorbs one more word before in_ready drops. Each accepted word counts as
// one tick of the internal TICK_WIDTH-bit time base.
// Configuration writes take effect at once and should be made while idle.
module button_click_qualifier_unit import bcq_pkg::*; #(
  parameter int TICK_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 button_pin,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                click_event
);

  cfg_t   cfg;
  logic   a_valid;
  logic   a_pin;
  logic   step;
  event_t ev;
  event_t ev_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= DEBOUNCE_RST;
      cfg.interference_ticks <= INTERFERENCE_RST;
      cfg.long_click_ticks   <= LONG_CLICK_RST;
      cfg.click_mode         <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:     cfg.debounce_ticks     <= cfg_data;
        REG_INTERFERENCE: cfg.interference_ticks <= cfg_data;
        REG_LONG_CLICK:   cfg.long_click_ticks   <= cfg_data;
        REG_CLICK_MODE:   cfg.click_mode         <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // core advances when a word is held and the result slot is free or draining
  assign step     = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
    end else if (step) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) a_pin <= button_pin;
  end

  bcq_core #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (step),
    .pin     (a_pin),
    .cfg     (cfg),
    .ev      (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) ev_held <= ev;
  end

  assign click_event = ev_held;

endmodule

`default_nettype wire

>>> hw/rtl/bcq_core.sv
// Qualifier state machine: stage, saved timestamps and the tick count that advances per step.
// Advances one sample per step and reports the click event for it.
// Depends on bcq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcq_core import bcq_pkg::*; #(
  parameter int TICK_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step_en,
  input  wire logic pin,
  input  wire cfg_t cfg,
  output event_t    ev
);

  // compare width wide enough for the 17-bit window sum
  localparam int CW = (TICK_WIDTH > 17) ? TICK_WIDTH : 17;

  stage_t                  stage, stage_next;
  logic                    prior_was_long, prior_was_long_next;
  logic [TICK_WIDTH-1:0]   stage_start_tick, stage_start_tick_next;
  logic [TICK_WIDTH-1:0]   press_start_tick, press_start_tick_next;
  logic [TICK_WIDTH-1:0]   tick_count;

  logic [TICK_WIDTH-1:0]   elapsed;
  logic [CW-1:0]           elapsed_x;
  logic [16:0]             window;
  logic                    deb_done, win_done, long_done;
  event_t                  ev_raw;

  assign elapsed   = tick_count - stage_start_tick;
  assign elapsed_x = CW'(elapsed);
  assign window    = {1'b0, cfg.debounce_ticks} + {1'b0, cfg.interference_ticks};
  assign deb_done  = elapsed_x >= CW'(cfg.debounce_ticks);
  assign win_done  = elapsed_x >= CW'(window);
  assign long_done = elapsed_x >= CW'(cfg.long_click_ticks);

  always_comb begin
    stage_next            = stage;
    prior_was_long_next   = prior_was_long;
    stage_start_tick_next = stage_start_tick;
    press_start_tick_next = press_start_tick;
    ev_raw                = EV_NONE;
    case (stage)
      ST_PASSIVE: begin
        if (!pin) begin
          stage_next            = ST_DEB_PRESS;
          stage_start_tick_next = tick_count;
        end
      end
      ST_DEB_PRESS: begin
        if (deb_done) stage_next = ST_INT_PRESS;
      end
      ST_INT_PRESS: begin
        if (pin) begin
          stage_next = ST_PASSIVE;
        end else if (win_done) begin
          stage_next = ST_WAIT_REL;
          if (!cfg.click_mode) ev_raw = EV_SINGLE;
        end
      end
      ST_WAIT_REL: begin
        if (pin) begin
          stage_next            = ST_DEB_REL;
          prior_was_long_next   = 1'b0;
          press_start_tick_next = stage_start_tick;
          stage_start_tick_next = tick_count;
        end else if (cfg.click_mode && long_done) begin
          stage_next          = ST_WAIT_REL_LONG;
          prior_was_long_next = 1'b0;
          ev_raw              = EV_LONG_PRESS;
        end
      end
      ST_WAIT_REL_LONG: begin
        if (pin) begin
          stage_next            = ST_DEB_REL;
          prior_was_long_next   = 1'b1;
          press_start_tick_next = stage_start_tick;
          stage_start_tick_next = tick_count;
        end
      end
      ST_DEB_REL: begin
        if (deb_done) stage_next = ST_INT_REL;
      end
      ST_INT_REL: begin
        if (!pin) begin
          // release glitch: back to the hold stage with the press timestamp
          stage_start_tick_next = press_start_tick;
          stage_next = prior_was_long ? ST_WAIT_REL_LONG : ST_WAIT_REL;
        end else if (win_done) begin
          stage_next = ST_PASSIVE;
          if (cfg.click_mode) ev_raw = prior_was_long ? EV_LONG_RELEASE : EV_SINGLE;
        end
      end
      default: begin
        stage_next = ST_PASSIVE;
      end
    endcase
  end

  assign ev = step_en ? ev_raw : EV_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage            <= ST_PASSIVE;
      prior_was_long   <= 1'b0;
      stage_start_tick <= '0;
      press_start_tick <= '0;
      tick_count       <= '0;
    end else if (step_en) begin
      stage            <= stage_next;
      prior_was_long   <= prior_was_long_next;
      stage_start_tick <= stage_start_tick_next;
      press_start_tick <= press_start_tick_next;
      tick_count       <= tick_count + TICK_WIDTH'(1);
    end
  end

  a_no_event_idle: assert property (@(posedge clk) disable iff (rst)
    !step_en |-> ev == EV_NONE) else $error("event without a step");

  a_long_press_stage: assert property (@(posedge clk) disable iff (rst)
    (step_en && ev == EV_LONG_PRESS) |=> stage == ST_WAIT_REL_LONG)
    else $error("long press did not enter long hold stage");

  a_long_release_src: assert property (@(posedge clk) disable iff (rst)
    (step_en && ev == EV_LONG_RELEASE) |-> (prior_was_long && stage == ST_INT_REL))
    else $error("long release without prior long press");

  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    (!rst && step_en) |=> tick_count == $past(tick_count) + TICK_WIDTH'(1))
    else $error("tick count did not advance on a step");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for button_click_qualifier_unit.
// Holds a click predictor in a small scoreboard class; plain tasks drive pin samples and
// config writes. Depends on bcq_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb;
  import bcq_pkg::*;

  localparam int TICK_W      = 32;
  localparam int CYCLE_LIMIT = 100000;

  // Tracks qualifier state and queues the click event due for each accepted sample.
  class click_scoreboard;
    logic [15:0]       deb_ticks;
    logic [15:0]       intf_ticks;
    logic [15:0]       long_ticks;
    logic              long_mode;
    stage_t            stage;
    logic              was_long;
    logic [TICK_W-1:0] mark_tick;
    logic [TICK_W-1:0] press_tick;
    logic [TICK_W-1:0] now_tick;
    event_t            click_q[$];
    int                errors;

    function new();
      deb_ticks  = DEBOUNCE_RST;
      intf_ticks = INTERFERENCE_RST;
      long_ticks = LONG_CLICK_RST;
      long_mode  = 1'b0;
      stage      = ST_PASSIVE;
      was_long   = 1'b0;
      mark_tick  = '0;
      press_tick = '0;
      now_tick   = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DEBOUNCE:     deb_ticks  = val;
        REG_INTERFERENCE: intf_ticks = val;
        REG_LONG_CLICK:   long_ticks = val;
        REG_CLICK_MODE:   long_mode  = val[0];
        default: ;
      endcase
    endfunction

    function void start_release(logic from_long);
      stage      = ST_DEB_REL;
      was_long   = from_long;
      press_tick = mark_tick;
      mark_tick  = now_tick;
    endfunction

    // lvl high means the button is up
    function void predict_click(logic lvl);
      logic [TICK_W-1:0] elapsed;
      logic [16:0]       window;
      event_t            ev;
      elapsed = now_tick - mark_tick;
      // full 17-bit sum, no wrap
      window  = {1'b0, deb_ticks} + {1'b0, intf_ticks};
      ev      = EV_NONE;
      case (stage)
        ST_PASSIVE: begin
          if (!lvl) begin
            stage     = ST_DEB_PRESS;
            mark_tick = now_tick;
          end
        end
        ST_DEB_PRESS: begin
          if (elapsed >= deb_ticks) stage = ST_INT_PRESS;
        end
        ST_INT_PRESS: begin
          if (lvl) begin
            stage = ST_PASSIVE;
          end else if (elapsed >= window) begin
            stage = ST_WAIT_REL;
            if (!long_mode) ev = EV_SINGLE;
          end
        end
        ST_WAIT_REL: begin
          if (lvl) begin
            start_release(1'b0);
          end else if (long_mode && elapsed >= long_ticks) begin
            stage    = ST_WAIT_REL_LONG;
            was_long = 1'b0;
            ev       = EV_LONG_PRESS;
          end
        end
        ST_WAIT_REL_LONG: begin
          if (lvl) start_release(1'b1);
        end
        ST_DEB_REL: begin
          if (elapsed >= deb_ticks) stage = ST_INT_REL;
        end
        ST_INT_REL: begin
          if (!lvl) begin
            // glitch: back to holding, press time restored
            mark_tick = press_tick;
            stage     = was_long ? ST_WAIT_REL_LONG : ST_WAIT_REL;
          end else if (elapsed >= window) begin
            stage = ST_PASSIVE;
            if (long_mode) ev = was_long ? EV_LONG_RELEASE : EV_SINGLE;
          end
        end
        default: stage = ST_PASSIVE;
      endcase
      now_tick = now_tick + 1'b1;
      click_q.push_back(ev);
    endfunction

    function void check_click(logic [1:0] got);
      event_t want;
      if (click_q.size() == 0) begin
        $error("click_event: expected none pending, actual %0d", got);
        errors++;
        return;
      end
      want = click_q.pop_front();
      if (got !== want) begin
        $error("click_event: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return click_q.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  button_pin = 1'b1;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            click_event;

  logic                  steady    = 1'b0;
  logic                  out_fire  = 1'b0;
  logic [1:0]            out_word  = '0;
  int                    cycle_count = 0;
  click_scoreboard       sb;

  button_click_qualifier_unit #(.TICK_WIDTH(TICK_W)) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .button_pin  (button_pin),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .click_event (click_event)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 19);
  end

  // sample the output side mid-cycle, score it at the edge that takes the word
  always @(negedge clk) begin
    out_fire = !rst && (out_valid === 1'b1) && out_ready;
    out_word = click_event;
  end

  always @(posedge clk) begin
    if (out_fire) sb.check_click(out_word);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_sample(input logic lvl);
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    button_pin <= lvl;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    sb.predict_click(lvl);
    @(posedge clk);
  endtask

  task automatic send_run(input logic lvl, input int count);
    repeat (count) send_sample(lvl);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // unused index goes last so a bad decode would clobber a live register
  task automatic write_config(input logic [15:0] deb, input logic [15:0] intf,
                              input logic [15:0] lng, input logic mode);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_INTERFERENCE, intf);
    write_reg(REG_LONG_CLICK, lng);
    write_reg(REG_CLICK_MODE, {15'($urandom), mode});
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_CLICK_MODE) + 1, (1 << CFG_IDX_W) - 1)),
              16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // alternating press/release runs; mostly long enough to qualify, some short glitches
  task automatic random_phase(input int n_items);
    int   left;
    int   run;
    int   lo;
    int   hi;
    logic lvl;
    lvl  = 1'($urandom_range(0, 1));
    left = n_items;
    while (left > 0) begin
      hi = int'(sb.deb_ticks) + int'(sb.intf_ticks) + int'(sb.long_ticks) + 3;
      if (hi > 60) hi = 60;
      lo = int'(sb.deb_ticks) + int'(sb.intf_ticks) + 1;
      if (lo > hi) lo = hi;
      if ($urandom_range(0, 99) < 20) run = $urandom_range(1, 3);
      else run = $urandom_range(lo, hi);
      if (run > left) run = left;
      send_run(lvl, run);
      left -= run;
      lvl = !lvl;
    end
  endtask

  function automatic logic [15:0] pick_ticks(input int top);
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, top));
  endfunction

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values: one press and release at 50 + 50 ticks, single-click mode
    send_run(1'b0, $urandom_range(110, 140));
    send_run(1'b1, $urandom_range(110, 140));
    drain();

    // directed: long press, release glitch, cancel, mode change mid-press
    write_config(16'd1, 16'd1, 16'd6, 1'b1);
    send_run(1'b1, 1);
    send_run(1'b0, 8);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 3);
    send_run(1'b0, 2);
    send_run(1'b1, 1);
    send_run(1'b0, 3);
    drain();
    write_reg(REG_CLICK_MODE, {15'($urandom), 1'b0});
    cfg_we <= 1'b0;
    send_run(1'b0, 5);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 3);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: write_config(16'd0, 16'd0, 16'd0, 1'b0);
        1: write_config(16'd0, 16'd0, 16'd0, 1'b1);
        2: write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        3: write_config(16'd2, 16'hFFFF, 16'd10, 1'($urandom));
        4: write_config(16'd1, 16'd2, 16'hFFFF, 1'b1);
        default: write_config(pick_ticks(6), pick_ticks(6), pick_ticks(40), 1'($urandom));
      endcase
      steady <= (p == 6 || p == 7);
      random_phase(90);
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
